// ===== sv/pnf_pkg.sv =====
// shared types, constants and helpers of the printf number formatter
package pnf_pkg;

    localparam int CHAR_W     = 8;
    localparam int ARG_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int DEC_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);
    localparam int POS_W      = 5;
    // depth must stay a power of two so the pointers wrap on their own
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // quotient by ten as (v * ceil(2^35 / 10)) >> 35, exact for 32-bit v
    localparam logic [ARG_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int DEC_SHIFT = 35;

    localparam logic [POS_W-1:0] BIN_TOP_POS = 5'd31;
    localparam logic [POS_W-1:0] OCT_TOP_POS = 5'd10;
    localparam logic [POS_W-1:0] HEX_TOP_POS = 5'd7;

    localparam logic [CHAR_W-1:0] ASC_PCT   = 8'h25;
    localparam logic [CHAR_W-1:0] ASC_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASC_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASC_ALPHA = 8'h37;
    localparam logic [CHAR_W-1:0] CONV_B    = 8'h62;
    localparam logic [CHAR_W-1:0] CONV_C    = 8'h63;
    localparam logic [CHAR_W-1:0] CONV_D    = 8'h64;
    localparam logic [CHAR_W-1:0] CONV_O    = 8'h6F;
    localparam logic [CHAR_W-1:0] CONV_P    = 8'h70;
    localparam logic [CHAR_W-1:0] CONV_U    = 8'h75;
    localparam logic [CHAR_W-1:0] CONV_X    = 8'h78;

    typedef enum logic [2:0] {
        CMD_CHAR,
        CMD_SDEC,
        CMD_UDEC,
        CMD_BIN,
        CMD_OCT,
        CMD_HEX
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
        logic [ARG_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAG,
        ST_POW,
        ST_DGEN,
        ST_DOUT
    } back_state_t;

    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] base;
        base = (d < 4'd10) ? ASC_ZERO : ASC_ALPHA;
        return base + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    endfunction

    function automatic logic [CHAR_W-1:0] tag_char(input cmd_kind_t kind);
        logic [CHAR_W-1:0] t;
        case (kind)
            CMD_BIN: t = CONV_B;
            CMD_OCT: t = CONV_O;
            default: t = CONV_X;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/pnf_front.sv =====
// front end: percent tracking and conversion decode into commands
module pnf_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pnf_pkg::CHAR_W-1:0]  format_char,
    input  logic [pnf_pkg::ARG_W-1:0]   argument,
    input  pnf_pkg::q_status_t          q_stat,
    output logic                        push,
    output pnf_pkg::cmd_t               push_cmd,
    output logic                        pending
);

    logic pending_reg;
    logic pending_next;
    logic accept;
    logic emit;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign pending  = pending_reg;

    always_comb
    begin
        push_cmd.kind  = pnf_pkg::CMD_CHAR;
        push_cmd.ch    = format_char;
        push_cmd.value = argument;
        emit           = 1'b0;
        if (!pending_reg)
        begin
            emit = (format_char != pnf_pkg::ASC_PCT);
        end
        else
        begin
            unique case (format_char)
                pnf_pkg::CONV_D:
                begin
                    push_cmd.kind = pnf_pkg::CMD_SDEC;
                    emit          = 1'b1;
                end
                pnf_pkg::CONV_U:
                begin
                    push_cmd.kind = pnf_pkg::CMD_UDEC;
                    emit          = 1'b1;
                end
                pnf_pkg::CONV_B:
                begin
                    push_cmd.kind = pnf_pkg::CMD_BIN;
                    emit          = 1'b1;
                end
                pnf_pkg::CONV_X, pnf_pkg::CONV_P:
                begin
                    push_cmd.kind = pnf_pkg::CMD_HEX;
                    emit          = 1'b1;
                end
                pnf_pkg::CONV_O:
                begin
                    push_cmd.kind = pnf_pkg::CMD_OCT;
                    emit          = 1'b1;
                end
                pnf_pkg::CONV_C:
                begin
                    push_cmd.ch = argument[pnf_pkg::CHAR_W-1:0];
                    emit        = 1'b1;
                end
                pnf_pkg::ASC_PCT:
                begin
                    emit = 1'b1;
                end
                default:
                begin
                    // unknown conversion letter: nothing comes out
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (accept)
        begin
            pending_next = pending_reg ? 1'b0 : (format_char == pnf_pkg::ASC_PCT);
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== sv/pnf_queue.sv =====
// short command queue between front end and back end
module pnf_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pnf_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output pnf_pkg::cmd_t       pop_cmd,
    output pnf_pkg::q_status_t  q_stat
);

    pnf_pkg::cmd_t               mem_reg [pnf_pkg::Q_DEPTH];
    logic [pnf_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [pnf_pkg::Q_PTR_W-1:0] wr_ptr_next;
    logic [pnf_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [pnf_pkg::Q_PTR_W-1:0] rd_ptr_next;
    logic [pnf_pkg::Q_CNT_W-1:0] cnt_reg;
    logic [pnf_pkg::Q_CNT_W-1:0] cnt_next;

    localparam logic [pnf_pkg::Q_CNT_W-1:0] FullCnt = pnf_pkg::Q_CNT_W'(pnf_pkg::Q_DEPTH);

    assign q_stat.full  = (cnt_reg == FullCnt);
    assign q_stat.empty = (cnt_reg == '0);
    assign pop_cmd      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sv/pnf_back.sv =====
// back end: digit sequencer and output register
module pnf_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pnf_pkg::q_status_t          q_stat,
    input  pnf_pkg::cmd_t               pop_cmd,
    output logic                        pop,
    output logic                        busy,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pnf_pkg::CHAR_W-1:0]  out_char,
    output logic                        last
);

    pnf_pkg::back_state_t state_reg;
    pnf_pkg::back_state_t state_next;
    pnf_pkg::cmd_kind_t   kind_reg;
    pnf_pkg::cmd_kind_t   kind_next;

    logic [pnf_pkg::ARG_W:0]       val_reg;
    logic [pnf_pkg::ARG_W:0]       val_next;
    logic [pnf_pkg::POS_W-1:0]     pos_reg;
    logic [pnf_pkg::POS_W-1:0]     pos_next;
    logic                          started_reg;
    logic                          started_next;
    logic [pnf_pkg::DIG_IDX_W-1:0] cnt_reg;
    logic [pnf_pkg::DIG_IDX_W-1:0] cnt_next;
    logic [pnf_pkg::DIGIT_W-1:0]   dbuf_reg [pnf_pkg::DEC_DIGITS];

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [pnf_pkg::CHAR_W-1:0]    out_char_reg;
    logic [pnf_pkg::CHAR_W-1:0]    out_char_next;
    logic                          last_reg;
    logic                          last_next;

    logic                          emit_ok;
    logic                          load_out;
    logic [pnf_pkg::CHAR_W-1:0]    new_char;
    logic                          new_last;
    logic                          dbuf_we;

    logic [2*pnf_pkg::ARG_W-1:0]   prod;
    logic [pnf_pkg::ARG_W-1:0]     quot;
    logic [pnf_pkg::ARG_W-1:0]     quot_x10;
    logic [pnf_pkg::DIGIT_W-1:0]   rem;
    logic [pnf_pkg::DIGIT_W-1:0]   pdig;
    logic [pnf_pkg::ARG_W:0]       val_shift;
    logic                          show_dig;

    assign emit_ok   = !out_valid_reg || !out_stall;
    assign busy      = (state_reg != pnf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    // divide by ten through the reciprocal, remainder from a shift-add
    assign prod     = val_reg[pnf_pkg::ARG_W-1:0] * pnf_pkg::DEC_RECIP;
    assign quot     = pnf_pkg::ARG_W'(prod[2*pnf_pkg::ARG_W-1:pnf_pkg::DEC_SHIFT]);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = pnf_pkg::DIGIT_W'(val_reg[pnf_pkg::ARG_W-1:0] - quot_x10);

    // power-of-two radices: top digit taken from the head of the shift register
    always_comb
    begin
        case (kind_reg)
            pnf_pkg::CMD_BIN:
            begin
                pdig      = {3'b000, val_reg[pnf_pkg::ARG_W]};
                val_shift = val_reg << 1;
            end
            pnf_pkg::CMD_OCT:
            begin
                pdig      = {1'b0, val_reg[pnf_pkg::ARG_W -: 3]};
                val_shift = val_reg << 3;
            end
            default:
            begin
                pdig      = val_reg[pnf_pkg::ARG_W -: 4];
                val_shift = val_reg << 4;
            end
        endcase
    end

    assign show_dig = (pdig != '0) || started_reg || (pos_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pnf_pkg::ST_IDLE:
            begin
                if (!q_stat.empty && emit_ok)
                begin
                    case (pop_cmd.kind)
                        pnf_pkg::CMD_CHAR:                   state_next = pnf_pkg::ST_IDLE;
                        pnf_pkg::CMD_SDEC, pnf_pkg::CMD_UDEC: state_next = pnf_pkg::ST_DGEN;
                        default:                             state_next = pnf_pkg::ST_TAG;
                    endcase
                end
            end
            pnf_pkg::ST_TAG:
            begin
                if (emit_ok)
                begin
                    state_next = pnf_pkg::ST_POW;
                end
            end
            pnf_pkg::ST_POW:
            begin
                if (emit_ok && pos_reg == '0)
                begin
                    state_next = pnf_pkg::ST_IDLE;
                end
            end
            pnf_pkg::ST_DGEN:
            begin
                if (quot == '0)
                begin
                    state_next = pnf_pkg::ST_DOUT;
                end
            end
            pnf_pkg::ST_DOUT:
            begin
                if (emit_ok && cnt_reg == '0)
                begin
                    state_next = pnf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pnf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        kind_next    = kind_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        cnt_next     = cnt_reg;
        load_out     = 1'b0;
        new_char     = pnf_pkg::ASC_ZERO;
        new_last     = 1'b0;
        dbuf_we      = 1'b0;
        unique case (state_reg)
            pnf_pkg::ST_IDLE:
            begin
                if (!q_stat.empty && emit_ok)
                begin
                    pop          = 1'b1;
                    kind_next    = pop_cmd.kind;
                    started_next = 1'b0;
                    cnt_next     = '0;
                    val_next     = {1'b0, pop_cmd.value};
                    case (pop_cmd.kind)
                        pnf_pkg::CMD_CHAR:
                        begin
                            load_out = 1'b1;
                            new_char = pop_cmd.ch;
                            new_last = 1'b1;
                        end
                        pnf_pkg::CMD_SDEC:
                        begin
                            if (pop_cmd.value[pnf_pkg::ARG_W-1])
                            begin
                                load_out = 1'b1;
                                new_char = pnf_pkg::ASC_MINUS;
                                val_next = {1'b0, pnf_pkg::ARG_W'(0) - pop_cmd.value};
                            end
                        end
                        pnf_pkg::CMD_UDEC:
                        begin
                            val_next = {1'b0, pop_cmd.value};
                        end
                        pnf_pkg::CMD_BIN:
                        begin
                            load_out = 1'b1;
                            val_next = {pop_cmd.value, 1'b0};
                            pos_next = pnf_pkg::BIN_TOP_POS;
                        end
                        pnf_pkg::CMD_OCT:
                        begin
                            load_out = 1'b1;
                            pos_next = pnf_pkg::OCT_TOP_POS;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                            val_next = {pop_cmd.value, 1'b0};
                            pos_next = pnf_pkg::HEX_TOP_POS;
                        end
                    endcase
                end
            end
            pnf_pkg::ST_TAG:
            begin
                if (emit_ok)
                begin
                    load_out = 1'b1;
                    new_char = pnf_pkg::tag_char(kind_reg);
                end
            end
            pnf_pkg::ST_POW:
            begin
                if (emit_ok)
                begin
                    // leading zero digits are skipped, the last position always shows
                    val_next     = val_shift;
                    pos_next     = pos_reg - 1'b1;
                    started_next = started_reg || (pdig != '0);
                    load_out     = show_dig;
                    new_char     = pnf_pkg::hex_glyph(pdig);
                    new_last     = (pos_reg == '0);
                end
            end
            pnf_pkg::ST_DGEN:
            begin
                dbuf_we  = 1'b1;
                val_next = {1'b0, quot};
                if (quot != '0)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pnf_pkg::ST_DOUT:
            begin
                if (emit_ok)
                begin
                    load_out = 1'b1;
                    new_char = pnf_pkg::hex_glyph(dbuf_reg[cnt_reg]);
                    new_last = (cnt_reg == '0);
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_char_next  = new_char;
            last_next      = new_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dbuf_we)
        begin
            dbuf_reg[cnt_reg] <= rem;
        end
        val_reg       <= val_next;
        out_char_reg  <= out_char_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pnf_pkg::ST_IDLE;
            kind_reg      <= pnf_pkg::CMD_CHAR;
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            pos_reg       <= pos_next;
            started_reg   <= started_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/printf_number_formatter.sv =====
// printf integer formatter: one format character in, zero to 34 characters out
// a plain character, a prefix or a minus sign passes through the command queue and the
// output register; decimal digits are first divided out by ten into a digit buffer
// and then emitted most significant first; out_stall holds the output register
// a two-entry command queue lets input be taken while the back end is emitting
// reset: rst_n asynchronous active low; clears percent flag, queue and sequencer
module printf_number_formatter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pnf_pkg::CHAR_W-1:0]  format_char,
    input  logic [pnf_pkg::ARG_W-1:0]   argument,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pnf_pkg::CHAR_W-1:0]  out_char,
    output logic                        last
);

    pnf_pkg::q_status_t q_stat;
    pnf_pkg::cmd_t      push_cmd;
    pnf_pkg::cmd_t      pop_cmd;
    logic               push;
    logic               pop;
    logic               pending;
    logic               busy;

    pnf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .format_char (format_char),
        .argument    (argument),
        .q_stat      (q_stat),
        .push        (push),
        .push_cmd    (push_cmd),
        .pending     (pending)
    );

    pnf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    pnf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

    a_pct_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !pending && format_char == pnf_pkg::ASC_PCT) |=> pending)
        else $error("percent item did not arm the pending flag");

    a_conv_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && pending) |=> !pending)
        else $error("conversion item left the pending flag set");

    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && !busy && (!out_valid || !out_stall)) |=> (busy || out_valid))
        else $error("queued command not started by the back end");

endmodule

// ===== bench/printf_number_formatter_check.sv =====
// checker for the printf number formatter: predicts the emitted characters and compares them
`timescale 1ns / 100ps

module printf_number_formatter_check
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [pnf_pkg::CHAR_W-1:0] format_char,
    input  logic [pnf_pkg::ARG_W-1:0]  argument,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [pnf_pkg::CHAR_W-1:0] out_char,
    input  logic                       last,
    output int                         mismatch_count,
    output int                         waiting_chars
);

    localparam logic [16*pnf_pkg::CHAR_W-1:0] GLYPHS = "0123456789ABCDEF";
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [pnf_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } emitted_t;

    emitted_t                   expected_chars[$];
    logic [pnf_pkg::CHAR_W-1:0] item_chars[$];
    logic                       percent_armed = 1'b0;
    int                         mismatches    = 0;

    task automatic report_mismatch(input string what, input logic [pnf_pkg::ARG_W-1:0] got,
                                   input logic [pnf_pkg::ARG_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void push_digits(input logic [pnf_pkg::ARG_W-1:0] value,
                                        input int radix);
        logic [pnf_pkg::CHAR_W-1:0] digits[pnf_pkg::ARG_W];
        logic [pnf_pkg::ARG_W-1:0]  rest;
        int                         n;
        int                         d;
        rest = value;
        n = 0;
        // least significant digit first, then reversed into the item
        do
        begin
            d = int'(rest % radix);
            digits[n] = GLYPHS[pnf_pkg::CHAR_W*(15-d) +: pnf_pkg::CHAR_W];
            rest = rest / radix;
            n++;
        end
        while (rest != 0);
        for (int i = n - 1; i >= 0; i--)
            item_chars.push_back(digits[i]);
    endfunction

    function automatic void push_prefixed(input logic [pnf_pkg::CHAR_W-1:0] tag,
                                          input logic [pnf_pkg::ARG_W-1:0] value,
                                          input int radix);
        item_chars.push_back(pnf_pkg::ASC_ZERO);
        item_chars.push_back(tag);
        push_digits(value, radix);
    endfunction

    function automatic void predict_item(input logic [pnf_pkg::CHAR_W-1:0] ch,
                                         input logic [pnf_pkg::ARG_W-1:0] arg);
        item_chars.delete();
        if (!percent_armed)
        begin
            if (ch == pnf_pkg::ASC_PCT)
                percent_armed = 1'b1;
            else
                item_chars.push_back(ch);
        end
        else
        begin
            percent_armed = 1'b0;
            case (ch)
                pnf_pkg::CONV_D:
                begin
                    if (arg[pnf_pkg::ARG_W-1])
                    begin
                        item_chars.push_back(pnf_pkg::ASC_MINUS);
                        push_digits(~arg + 1'b1, 10);
                    end
                    else
                        push_digits(arg, 10);
                end
                pnf_pkg::CONV_U: push_digits(arg, 10);
                pnf_pkg::CONV_B: push_prefixed(pnf_pkg::CONV_B, arg, 2);
                pnf_pkg::CONV_X, pnf_pkg::CONV_P: push_prefixed(pnf_pkg::CONV_X, arg, 16);
                pnf_pkg::CONV_O: push_prefixed(pnf_pkg::CONV_O, arg, 8);
                pnf_pkg::CONV_C: item_chars.push_back(arg[pnf_pkg::CHAR_W-1:0]);
                pnf_pkg::ASC_PCT: item_chars.push_back(pnf_pkg::ASC_PCT);
                default:        ;
            endcase
        end
        foreach (item_chars[i])
            expected_chars.push_back({item_chars[i], i == item_chars.size() - 1});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        emitted_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            percent_armed = 1'b0;
        end
        else
        begin
            // results first: nothing taken at this edge can already be on the output
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected out_char", pnf_pkg::ARG_W'(out_char), '0);
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch("out_char", pnf_pkg::ARG_W'(out_char),
                                        pnf_pkg::ARG_W'(want.ch));
                    if (last !== want.last)
                        report_mismatch("last", pnf_pkg::ARG_W'(last),
                                        pnf_pkg::ARG_W'(want.last));
                end
            end
            if (in_valid && !in_stall)
                predict_item(format_char, argument);
        end
        mismatch_count <= mismatches;
        waiting_chars  <= expected_chars.size();
    end

endmodule

// ===== bench/printf_number_formatter_test.sv =====
// testbench top of the printf number formatter: stimulus, idling and verdict
`timescale 1ns / 100ps

module printf_number_formatter_test;

    localparam logic [pnf_pkg::CHAR_W-1:0] CONV_STR = 8'h73;
    localparam logic [pnf_pkg::CHAR_W-1:0] ASC_NUL  = 8'h00;
    localparam logic [pnf_pkg::CHAR_W-1:0] ASC_TOP  = 8'hFF;
    localparam int ITEM_TARGET    = 300;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic [pnf_pkg::CHAR_W-1:0] format_char = '0;
    logic [pnf_pkg::ARG_W-1:0]  argument    = '0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic [pnf_pkg::CHAR_W-1:0] out_char;
    logic                       last;

    int mismatch_count;
    int waiting_chars;
    int items_sent  = 0;
    int quiet_count = 0;
    int stall_left  = 0;
    bit idle_on     = 1'b1;

    printf_number_formatter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .format_char (format_char),
        .argument    (argument),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last        (last)
    );

    printf_number_formatter_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .format_char    (format_char),
        .argument       (argument),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .last           (last),
        .mismatch_count (mismatch_count),
        .waiting_chars  (waiting_chars)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall bursts, started at random while idle_on is set
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_count <= 0;
            else if (quiet_count >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                quiet_count <= quiet_count + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input logic [pnf_pkg::CHAR_W-1:0] ch,
                             input logic [pnf_pkg::ARG_W-1:0] arg);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        format_char <= ch;
        argument    <= arg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        idle_on = !((items_sent >= 120 && items_sent < 160) || items_sent >= 240);
    endtask

    task automatic send_conversion(input logic [pnf_pkg::CHAR_W-1:0] conv,
                                   input logic [pnf_pkg::ARG_W-1:0] arg);
        send_item(pnf_pkg::ASC_PCT, $urandom);
        send_item(conv, arg);
    endtask

    function automatic logic [pnf_pkg::ARG_W-1:0] pick_arg();
        logic [pnf_pkg::ARG_W-1:0] a;
        case ($urandom_range(0, 4))
            0:       a = $urandom_range(0, 20);
            1:       a = $urandom >> $urandom_range(0, 31);
            2:       a = {1'b1, 31'($urandom >> $urandom_range(0, 31))};
            3:       a = $urandom_range(0, 1) ? '1 : 32'h8000_0000;
            default: a = $urandom;
        endcase
        return a;
    endfunction

    function automatic logic [pnf_pkg::CHAR_W-1:0] pick_conversion();
        logic [pnf_pkg::CHAR_W-1:0] c;
        case ($urandom_range(0, 7))
            0:       c = pnf_pkg::CONV_D;
            1:       c = pnf_pkg::CONV_U;
            2:       c = pnf_pkg::CONV_B;
            3:       c = pnf_pkg::CONV_X;
            4:       c = pnf_pkg::CONV_P;
            5:       c = pnf_pkg::CONV_O;
            6:       c = pnf_pkg::CONV_C;
            default: c = pnf_pkg::ASC_PCT;
        endcase
        return c;
    endfunction

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, every conversion, unknown and zero conversion bytes
        send_item(ASC_NUL, '0);
        send_item(ASC_TOP, '1);
        send_conversion(pnf_pkg::CONV_D, 32'h8000_0000);
        send_conversion(pnf_pkg::CONV_D, 32'h7FFF_FFFF);
        send_conversion(pnf_pkg::CONV_U, 32'hFFFF_FFFF);
        send_conversion(pnf_pkg::CONV_U, 32'h0000_0000);
        send_conversion(pnf_pkg::CONV_B, 32'hFFFF_FFFF);
        send_conversion(pnf_pkg::CONV_X, 32'hFFFF_FFFF);
        send_conversion(pnf_pkg::CONV_P, 32'h0000_0000);
        send_conversion(pnf_pkg::CONV_O, 32'hFFFF_FFFF);
        send_conversion(pnf_pkg::CONV_C, 32'h0000_00A5);
        send_conversion(pnf_pkg::ASC_PCT, 32'h1234_5678);
        send_conversion(CONV_STR, 32'h0000_0001);
        send_conversion(ASC_NUL, 32'h0000_0002);

        // random: mostly well-formed conversions, some plain text and noise
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(pnf_pkg::CHAR_W'($urandom), $urandom);
                9:
                begin
                    if ($urandom_range(0, 1))
                        send_conversion(pnf_pkg::CHAR_W'($urandom), $urandom);
                    else
                        send_item(pnf_pkg::ASC_PCT, $urandom);
                end
                default: send_conversion(pick_conversion(), pick_arg());
            endcase
        end
        in_valid <= 1'b0;

        while (waiting_chars != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
